// ===== src/mips_ieu_pkg.sv =====
// ----------------------------------------------------------------------------
// mips_ieu_pkg
// Opcodes, field widths and shared types of the integer execute unit.
// ----------------------------------------------------------------------------
package mips_ieu_pkg;

  localparam int unsigned DefRegCount = 32;
  localparam int unsigned DefDataWidth = 64;
  localparam int unsigned IdxW = 5;

  typedef enum logic [5:0] {
    CMD_SLL = 6'd0, CMD_SRL = 6'd1, CMD_SRA = 6'd2, CMD_SLLV = 6'd3,
    CMD_SRLV = 6'd4, CMD_SRAV = 6'd5, CMD_DSLL = 6'd6, CMD_DSRL = 6'd7,
    CMD_DSRA = 6'd8, CMD_DSLL32 = 6'd9, CMD_DSRL32 = 6'd10, CMD_DSRA32 = 6'd11,
    CMD_DSLLV = 6'd12, CMD_DSRLV = 6'd13, CMD_DSRAV = 6'd14, CMD_ADDU = 6'd15,
    CMD_SUBU = 6'd16, CMD_DADDU = 6'd17, CMD_DSUBU = 6'd18, CMD_AND = 6'd19,
    CMD_OR = 6'd20, CMD_XOR = 6'd21, CMD_NOR = 6'd22, CMD_SLT = 6'd23,
    CMD_SLTU = 6'd24, CMD_MOVZ = 6'd25, CMD_MOVN = 6'd26, CMD_ADDIU = 6'd27,
    CMD_DADDIU = 6'd28, CMD_SLTI = 6'd29, CMD_SLTIU = 6'd30, CMD_ANDI = 6'd31,
    CMD_ORI = 6'd32, CMD_XORI = 6'd33, CMD_LUI = 6'd34, CMD_MULT = 6'd35,
    CMD_DIV = 6'd36, CMD_DIVU = 6'd37, CMD_MULT1 = 6'd38, CMD_DIVU1 = 6'd39,
    CMD_MFHI = 6'd40, CMD_MFLO = 6'd41, CMD_MTHI = 6'd42, CMD_MTLO = 6'd43,
    CMD_MFHI1 = 6'd44, CMD_MFLO1 = 6'd45, CMD_MTHI1 = 6'd46, CMD_MTLO1 = 6'd47,
    CMD_MFSA = 6'd48, CMD_MTSA = 6'd49
  } cmd_t;

  // divider request and answer
  typedef struct packed {
    logic        start;
    logic        sgn;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
    logic [31:0] rem;
  } div_rsp_t;

endpackage

// ===== src/mips_ieu_div.sv =====
// ----------------------------------------------------------------------------
// mips_ieu_div
// Radix-2 restoring divider, 32-bit magnitude, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module mips_ieu_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mips_ieu_pkg::div_req_t req,
  output mips_ieu_pkg::div_rsp_t rsp
);

  logic        busy_r, busy_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] den_r, den_nxt;
  logic        qneg_r, qneg_nxt, rneg_r, rneg_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;
  logic [32:0] shifted;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    qneg_nxt = qneg_r;
    rneg_nxt = rneg_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[31:0], q_r[31]};
    trial    = shifted - {1'b0, den_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd0;
      rem_nxt  = '0;
      // magnitudes for the signed form
      q_nxt    = (req.sgn && req.num[31]) ? (32'd0 - req.num) : req.num;
      den_nxt  = (req.sgn && req.den[31]) ? (32'd0 - req.den) : req.den;
      qneg_nxt = req.sgn && (req.num[31] ^ req.den[31]);
      rneg_nxt = req.sgn && req.num[31];
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial;
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    qneg_r <= qneg_nxt;
    rneg_r <= rneg_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = qneg_r ? (32'd0 - q_r) : q_r;
  assign rsp.rem  = rneg_r ? (32'd0 - rem_r[31:0]) : rem_r[31:0];

endmodule

// ===== src/mips64_integer_execute_unit.sv =====
// ----------------------------------------------------------------------------
// mips64_integer_execute_unit
// Integer execute stage with a 64-bit register file and two HI/LO pairs.
// ----------------------------------------------------------------------------
// Each input word is one decoded instruction and yields one result word. The
// register file sits in two synchronous memories (one per read port), so an
// instruction passes read, execute/write back and result steps. Multiplies
// add the ST_MUL state for the registered product; divides then run a radix-2
// unit in ST_DIV. One instruction is in flight at a time; a new one is taken
// while the previous result still waits in the output register. No clearing
// pass: register valid bits give the reset value of zero.
module mips64_integer_execute_unit #(
  parameter int unsigned REGISTER_COUNT = mips_ieu_pkg::DefRegCount,
  parameter int unsigned DATA_WIDTH     = mips_ieu_pkg::DefDataWidth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cmd[5:0] src_index[10:6] tgt_index[15:11] dst_index[20:16]
  // shift_count[25:21] immediate[41:26], zero fill to 48
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // write_enable[0] write_index[5:1] write_value[69:6] divide_error[70]
  output logic [71:0] out_tdata
);

  localparam int unsigned RegIdxW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
  localparam int unsigned Dw = DATA_WIDTH;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001, ST_READ = 5'b00010, ST_EXEC = 5'b00100,
    ST_MUL  = 5'b01000, ST_DIV  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // instruction fields
  logic [5:0]  cmd_r;
  logic [4:0]  rs_i_r, rt_i_r, rd_i_r, sa_r;
  logic [15:0] imm_r;

  // register file: two copies for two reads
  logic [Dw-1:0] rf_a [REGISTER_COUNT];
  logic [Dw-1:0] rf_b [REGISTER_COUNT];
  logic [Dw-1:0] rda_r, rdb_r;
  logic [REGISTER_COUNT-1:0] vld_r;

  logic [Dw-1:0] hi_r, lo_r, hi1_r, lo1_r, sa_reg_r;
  logic [63:0]   prod_r;

  logic          ovld_r;
  logic [71:0]   odata_r;

  logic          out_free;
  logic [Dw-1:0] rs, rt;
  logic          rs_ok, rt_ok;
  logic [Dw-1:0] val;
  logic [4:0]    dest;
  logic          wr, wr_ok, fin, derr;
  logic [Dw-1:0] simm, rt_lo_s;
  logic [5:0]    amt;
  logic [31:0]   w32;

  mips_ieu_pkg::div_req_t dreq;
  mips_ieu_pkg::div_rsp_t drsp;

  mips_ieu_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign out_free  = !ovld_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;

  // register read, index beyond the file or unwritten reads zero
  assign rs_ok = (rs_i_r != 5'd0) && ({27'd0, rs_i_r} < REGISTER_COUNT)
                 && vld_r[rs_i_r[RegIdxW-1:0]];
  assign rt_ok = (rt_i_r != 5'd0) && ({27'd0, rt_i_r} < REGISTER_COUNT)
                 && vld_r[rt_i_r[RegIdxW-1:0]];
  assign rs = rs_ok ? rda_r : '0;
  assign rt = rt_ok ? rdb_r : '0;

  assign simm    = {{(Dw-16){imm_r[15]}}, imm_r};
  assign rt_lo_s = {{(Dw-32){rt[31]}}, rt[31:0]};

  function automatic logic [63:0] sx32(input logic [31:0] v);
    sx32 = {{32{v[31]}}, v};
  endfunction

  always_comb begin
    val  = '0;
    dest = rd_i_r;
    wr   = 1'b0;
    amt  = '0;
    w32  = '0;
    case (mips_ieu_pkg::cmd_t'(cmd_r))
      mips_ieu_pkg::CMD_SLL:    begin w32 = rt[31:0] << sa_r; val = sx32(w32); wr = 1'b1; end
      mips_ieu_pkg::CMD_SRL:    begin w32 = rt[31:0] >> sa_r; val = sx32(w32); wr = 1'b1; end
      mips_ieu_pkg::CMD_SRA:    begin val = $signed(rt_lo_s) >>> sa_r; wr = 1'b1; end
      mips_ieu_pkg::CMD_SLLV:   begin
        w32 = rt[31:0] << rs[4:0]; val = sx32(w32); wr = 1'b1;
      end
      mips_ieu_pkg::CMD_SRLV:   begin
        w32 = rt[31:0] >> rs[4:0]; val = sx32(w32); wr = 1'b1;
      end
      mips_ieu_pkg::CMD_SRAV:   begin val = $signed(rt_lo_s) >>> rs[4:0]; wr = 1'b1; end
      mips_ieu_pkg::CMD_DSLL:   begin val = rt << sa_r; wr = 1'b1; end
      mips_ieu_pkg::CMD_DSRL:   begin val = rt >> sa_r; wr = 1'b1; end
      mips_ieu_pkg::CMD_DSRA:   begin val = $signed(rt) >>> sa_r; wr = 1'b1; end
      mips_ieu_pkg::CMD_DSLL32: begin amt = {1'b1, sa_r}; val = rt << amt; wr = 1'b1; end
      mips_ieu_pkg::CMD_DSRL32: begin amt = {1'b1, sa_r}; val = rt >> amt; wr = 1'b1; end
      mips_ieu_pkg::CMD_DSRA32: begin
        amt = {1'b1, sa_r}; val = $signed(rt) >>> amt; wr = 1'b1;
      end
      mips_ieu_pkg::CMD_DSLLV:  begin val = rt << rs[5:0]; wr = 1'b1; end
      mips_ieu_pkg::CMD_DSRLV:  begin val = rt >> rs[5:0]; wr = 1'b1; end
      mips_ieu_pkg::CMD_DSRAV:  begin val = $signed(rt) >>> rs[5:0]; wr = 1'b1; end
      mips_ieu_pkg::CMD_ADDU:   begin
        w32 = rs[31:0] + rt[31:0]; val = sx32(w32); wr = 1'b1;
      end
      mips_ieu_pkg::CMD_SUBU:   begin
        w32 = rs[31:0] - rt[31:0]; val = sx32(w32); wr = 1'b1;
      end
      mips_ieu_pkg::CMD_DADDU:  begin val = rs + rt; wr = 1'b1; end
      mips_ieu_pkg::CMD_DSUBU:  begin val = rs - rt; wr = 1'b1; end
      mips_ieu_pkg::CMD_AND:    begin val = rs & rt; wr = 1'b1; end
      mips_ieu_pkg::CMD_OR:     begin val = rs | rt; wr = 1'b1; end
      mips_ieu_pkg::CMD_XOR:    begin val = rs ^ rt; wr = 1'b1; end
      mips_ieu_pkg::CMD_NOR:    begin val = ~(rs | rt); wr = 1'b1; end
      mips_ieu_pkg::CMD_SLT:    begin val = {63'd0, $signed(rs) < $signed(rt)}; wr = 1'b1; end
      mips_ieu_pkg::CMD_SLTU:   begin val = {63'd0, rs < rt}; wr = 1'b1; end
      mips_ieu_pkg::CMD_MOVZ:   begin val = rs; wr = (rt == '0); end
      mips_ieu_pkg::CMD_MOVN:   begin val = rs; wr = (rt != '0); end
      mips_ieu_pkg::CMD_ADDIU:  begin
        w32 = rs[31:0] + simm[31:0];
        val = sx32(w32); dest = rt_i_r; wr = 1'b1;
      end
      mips_ieu_pkg::CMD_DADDIU: begin val = rs + simm; dest = rt_i_r; wr = 1'b1; end
      mips_ieu_pkg::CMD_SLTI:   begin
        val = {63'd0, $signed(rs) < $signed(simm)}; dest = rt_i_r; wr = 1'b1;
      end
      mips_ieu_pkg::CMD_SLTIU:  begin val = {63'd0, rs < simm}; dest = rt_i_r; wr = 1'b1; end
      mips_ieu_pkg::CMD_ANDI:   begin val = rs & {48'd0, imm_r}; dest = rt_i_r; wr = 1'b1; end
      mips_ieu_pkg::CMD_ORI:    begin val = rs | {48'd0, imm_r}; dest = rt_i_r; wr = 1'b1; end
      mips_ieu_pkg::CMD_XORI:   begin val = rs ^ {48'd0, imm_r}; dest = rt_i_r; wr = 1'b1; end
      mips_ieu_pkg::CMD_LUI:    begin val = sx32({imm_r, 16'd0}); dest = rt_i_r; wr = 1'b1; end
      mips_ieu_pkg::CMD_MULT,
      mips_ieu_pkg::CMD_MULT1:  begin val = sx32(prod_r[31:0]); wr = 1'b1; end
      mips_ieu_pkg::CMD_MFHI:   begin val = hi_r; wr = 1'b1; end
      mips_ieu_pkg::CMD_MFLO:   begin val = lo_r; wr = 1'b1; end
      mips_ieu_pkg::CMD_MFHI1:  begin val = hi1_r; wr = 1'b1; end
      mips_ieu_pkg::CMD_MFLO1:  begin val = lo1_r; wr = 1'b1; end
      mips_ieu_pkg::CMD_MFSA:   begin val = sa_reg_r; wr = 1'b1; end
      default: ;
    endcase
  end

  assign wr_ok = wr && (dest != 5'd0) && ({27'd0, dest} < REGISTER_COUNT);
  assign derr  = (mips_ieu_pkg::cmd_t'(cmd_r) == mips_ieu_pkg::CMD_DIV) && (rt[31:0] == '0);

  // divider start in execute once the output is free and the divisor is nonzero
  always_comb begin
    dreq.start = 1'b0;
    dreq.sgn   = (mips_ieu_pkg::cmd_t'(cmd_r) == mips_ieu_pkg::CMD_DIV);
    dreq.num   = rs[31:0];
    dreq.den   = rt[31:0];
    if (state_r == ST_EXEC && out_free && rt[31:0] != '0 &&
        (mips_ieu_pkg::cmd_t'(cmd_r) == mips_ieu_pkg::CMD_DIV ||
         mips_ieu_pkg::cmd_t'(cmd_r) == mips_ieu_pkg::CMD_DIVU ||
         mips_ieu_pkg::cmd_t'(cmd_r) == mips_ieu_pkg::CMD_DIVU1))
      dreq.start = 1'b1;
  end

  always_comb begin
    state_nxt = state_r;
    fin = 1'b0;
    case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_READ;
      ST_READ: begin
        if (mips_ieu_pkg::cmd_t'(cmd_r) == mips_ieu_pkg::CMD_MULT ||
            mips_ieu_pkg::cmd_t'(cmd_r) == mips_ieu_pkg::CMD_MULT1)
          state_nxt = ST_MUL;
        else
          state_nxt = ST_EXEC;
      end
      ST_MUL:  state_nxt = ST_EXEC;
      ST_EXEC: if (out_free) begin
        if (dreq.start) state_nxt = ST_DIV;
        else begin
          state_nxt = ST_IDLE;
          fin = 1'b1;
        end
      end
      ST_DIV:  if (drsp.done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovld_r   <= 1'b0;
      vld_r    <= '0;
      hi_r     <= '0;
      lo_r     <= '0;
      hi1_r    <= '0;
      lo1_r    <= '0;
      sa_reg_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (fin || (state_r == ST_DIV && drsp.done)) ovld_r <= 1'b1;
      else if (out_tready) ovld_r <= 1'b0;
      if (fin) begin
        odata_r <= {1'b0, derr, (wr_ok ? val : 64'd0), (wr_ok ? dest : 5'd0), wr_ok};
        if (wr_ok) vld_r[dest[RegIdxW-1:0]] <= 1'b1;
        case (mips_ieu_pkg::cmd_t'(cmd_r))
          mips_ieu_pkg::CMD_MULT:  begin
            lo_r <= sx32(prod_r[31:0]); hi_r <= sx32(prod_r[63:32]);
          end
          mips_ieu_pkg::CMD_MULT1: begin
            lo1_r <= sx32(prod_r[31:0]); hi1_r <= sx32(prod_r[63:32]);
          end
          mips_ieu_pkg::CMD_DIVU:  begin lo_r <= '1; hi_r <= sx32(rs[31:0]); end
          mips_ieu_pkg::CMD_DIVU1: begin lo1_r <= '1; hi1_r <= sx32(rs[31:0]); end
          mips_ieu_pkg::CMD_MTHI:  hi_r <= rs;
          mips_ieu_pkg::CMD_MTLO:  lo_r <= rs;
          mips_ieu_pkg::CMD_MTHI1: hi1_r <= rs;
          mips_ieu_pkg::CMD_MTLO1: lo1_r <= rs;
          mips_ieu_pkg::CMD_MTSA:  sa_reg_r <= rs;
          default: ;
        endcase
      end
      if (state_r == ST_DIV && drsp.done) begin
        odata_r <= '0;
        if (mips_ieu_pkg::cmd_t'(cmd_r) == mips_ieu_pkg::CMD_DIVU1) begin
          lo1_r <= sx32(drsp.quo); hi1_r <= sx32(drsp.rem);
        end else begin
          lo_r <= sx32(drsp.quo); hi_r <= sx32(drsp.rem);
        end
      end
    end
  end

  // capture, register-file read and write, product
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid) begin
      cmd_r  <= in_tdata[5:0];
      rs_i_r <= in_tdata[10:6];
      rt_i_r <= in_tdata[15:11];
      rd_i_r <= in_tdata[20:16];
      sa_r   <= in_tdata[25:21];
      imm_r  <= in_tdata[41:26];
      rda_r  <= rf_a[in_tdata[6 +: RegIdxW]];
      rdb_r  <= rf_b[in_tdata[11 +: RegIdxW]];
    end
    if (state_r == ST_MUL)
      prod_r <= $signed(rs[31:0]) * $signed(rt[31:0]);
    if (fin && wr_ok) begin
      rf_a[dest[RegIdxW-1:0]] <= val;
      rf_b[dest[RegIdxW-1:0]] <= val;
    end
  end

endmodule

// ===== test/mips64_integer_execute_unit_checker.sv =====
// ----------------------------------------------------------------------------
// mips64_integer_execute_unit_checker
// Watches both stream channels of the execute unit, keeps a shadow register
// file with HI/LO pairs and the shift-amount register, predicts each result
// word and compares it field by field.
// ----------------------------------------------------------------------------
module mips64_integer_execute_unit_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        div_err;
    logic [63:0] wr_value;
    logic [4:0]  wr_index;
    logic        wr_en;
  } wb_t;

  logic [63:0] shadow_regs [32];
  logic [63:0] hi0, lo0, hi1, lo1, sa_reg;
  wb_t         wb_queue[$];

  function automatic logic [63:0] sx32(input logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] rd_reg(input logic [4:0] idx);
    return (idx == 0) ? 64'd0 : shadow_regs[idx];
  endfunction

  task automatic execute_instr(input logic [47:0] word);
    mips_ieu_pkg::cmd_t op;
    logic [4:0]  rs_i, rt_i, rd_i, dest, sa;
    logic [15:0] imm;
    logic [63:0] rs, rt, val, p;
    logic [31:0] n, d, a, b, q, r;
    logic        wr, derr;
    wb_t         res;
    op = mips_ieu_pkg::cmd_t'(word[5:0]);
    rs_i = word[10:6]; rt_i = word[15:11]; rd_i = word[20:16];
    sa = word[25:21]; imm = word[41:26];
    rs = rd_reg(rs_i); rt = rd_reg(rt_i);
    val = 0; dest = rd_i; wr = 0; derr = 0;
    n = rs[31:0]; d = rt[31:0];
    case (op)
      mips_ieu_pkg::CMD_SLL:    begin val = sx32(rt[31:0] << sa); wr = 1; end
      mips_ieu_pkg::CMD_SRL:    begin val = sx32(rt[31:0] >> sa); wr = 1; end
      mips_ieu_pkg::CMD_SRA:    begin val = $signed(sx32(rt)) >>> sa; wr = 1; end
      mips_ieu_pkg::CMD_SLLV:   begin val = sx32(rt[31:0] << rs[4:0]); wr = 1; end
      mips_ieu_pkg::CMD_SRLV:   begin val = sx32(rt[31:0] >> rs[4:0]); wr = 1; end
      mips_ieu_pkg::CMD_SRAV:   begin val = $signed(sx32(rt)) >>> rs[4:0]; wr = 1; end
      mips_ieu_pkg::CMD_DSLL:   begin val = rt << sa; wr = 1; end
      mips_ieu_pkg::CMD_DSRL:   begin val = rt >> sa; wr = 1; end
      mips_ieu_pkg::CMD_DSRA:   begin val = $signed(rt) >>> sa; wr = 1; end
      mips_ieu_pkg::CMD_DSLL32: begin val = rt << (7'd32 + sa); wr = 1; end
      mips_ieu_pkg::CMD_DSRL32: begin val = rt >> (7'd32 + sa); wr = 1; end
      mips_ieu_pkg::CMD_DSRA32: begin val = $signed(rt) >>> (7'd32 + sa); wr = 1; end
      mips_ieu_pkg::CMD_DSLLV:  begin val = rt << rs[5:0]; wr = 1; end
      mips_ieu_pkg::CMD_DSRLV:  begin val = rt >> rs[5:0]; wr = 1; end
      mips_ieu_pkg::CMD_DSRAV:  begin val = $signed(rt) >>> rs[5:0]; wr = 1; end
      mips_ieu_pkg::CMD_ADDU:   begin val = sx32(rs + rt); wr = 1; end
      mips_ieu_pkg::CMD_SUBU:   begin val = sx32(rs - rt); wr = 1; end
      mips_ieu_pkg::CMD_DADDU:  begin val = rs + rt; wr = 1; end
      mips_ieu_pkg::CMD_DSUBU:  begin val = rs - rt; wr = 1; end
      mips_ieu_pkg::CMD_AND:    begin val = rs & rt; wr = 1; end
      mips_ieu_pkg::CMD_OR:     begin val = rs | rt; wr = 1; end
      mips_ieu_pkg::CMD_XOR:    begin val = rs ^ rt; wr = 1; end
      mips_ieu_pkg::CMD_NOR:    begin val = ~(rs | rt); wr = 1; end
      mips_ieu_pkg::CMD_SLT: begin
        val = ($signed(rs) < $signed(rt)) ? 64'd1 : 64'd0; wr = 1;
      end
      mips_ieu_pkg::CMD_SLTU:   begin val = (rs < rt) ? 64'd1 : 64'd0; wr = 1; end
      mips_ieu_pkg::CMD_MOVZ:   begin val = rs; wr = (rt == 0); end
      mips_ieu_pkg::CMD_MOVN:   begin val = rs; wr = (rt != 0); end
      mips_ieu_pkg::CMD_ADDIU:  begin val = sx32(rs + sx16(imm)); dest = rt_i; wr = 1; end
      mips_ieu_pkg::CMD_DADDIU: begin val = rs + sx16(imm); dest = rt_i; wr = 1; end
      mips_ieu_pkg::CMD_SLTI: begin
        val = ($signed(rs) < $signed(sx16(imm))) ? 64'd1 : 64'd0; dest = rt_i; wr = 1;
      end
      mips_ieu_pkg::CMD_SLTIU: begin
        val = (rs < sx16(imm)) ? 64'd1 : 64'd0; dest = rt_i; wr = 1;
      end
      mips_ieu_pkg::CMD_ANDI:   begin val = rs & {48'd0, imm}; dest = rt_i; wr = 1; end
      mips_ieu_pkg::CMD_ORI:    begin val = rs | {48'd0, imm}; dest = rt_i; wr = 1; end
      mips_ieu_pkg::CMD_XORI:   begin val = rs ^ {48'd0, imm}; dest = rt_i; wr = 1; end
      mips_ieu_pkg::CMD_LUI:    begin val = sx32({imm, 16'd0}); dest = rt_i; wr = 1; end
      mips_ieu_pkg::CMD_MULT, mips_ieu_pkg::CMD_MULT1: begin
        p = $signed(sx32(rs)) * $signed(sx32(rt));
        val = sx32(p);
        if (op == mips_ieu_pkg::CMD_MULT) begin
          lo0 = val; hi0 = sx32(p >> 32);
        end else begin
          lo1 = val; hi1 = sx32(p >> 32);
        end
        wr = 1;
      end
      mips_ieu_pkg::CMD_DIV: begin
        if (d == 0) begin
          derr = 1;
        end else begin
          a = n[31] ? -n : n;
          b = d[31] ? -d : d;
          q = a / b; r = a % b;
          if (n[31] != d[31]) q = -q;
          if (n[31]) r = -r;
          lo0 = sx32(q); hi0 = sx32(r);
        end
      end
      mips_ieu_pkg::CMD_DIVU, mips_ieu_pkg::CMD_DIVU1: begin
        if (d == 0) begin
          q = '1; r = n;
        end else begin
          q = n / d; r = n % d;
        end
        if (op == mips_ieu_pkg::CMD_DIVU) begin
          lo0 = (d == 0) ? '1 : sx32(q); hi0 = sx32(r);
        end else begin
          lo1 = (d == 0) ? '1 : sx32(q); hi1 = sx32(r);
        end
      end
      mips_ieu_pkg::CMD_MFHI:  begin val = hi0; wr = 1; end
      mips_ieu_pkg::CMD_MFLO:  begin val = lo0; wr = 1; end
      mips_ieu_pkg::CMD_MTHI:  hi0 = rs;
      mips_ieu_pkg::CMD_MTLO:  lo0 = rs;
      mips_ieu_pkg::CMD_MFHI1: begin val = hi1; wr = 1; end
      mips_ieu_pkg::CMD_MFLO1: begin val = lo1; wr = 1; end
      mips_ieu_pkg::CMD_MTHI1: hi1 = rs;
      mips_ieu_pkg::CMD_MTLO1: lo1 = rs;
      mips_ieu_pkg::CMD_MFSA:  begin val = sa_reg; wr = 1; end
      mips_ieu_pkg::CMD_MTSA:  sa_reg = rs;
      default: ;
    endcase
    if (dest == 0) wr = 0;
    if (wr) shadow_regs[dest] = val;
    res.wr_en = wr;
    res.wr_index = wr ? dest : 5'd0;
    res.wr_value = wr ? val : 64'd0;
    res.div_err = derr;
    wb_queue.push_back(res);
  endtask

  always @(posedge clk) begin
    wb_t want, got;
    if (!rst_n) begin
      foreach (shadow_regs[i]) shadow_regs[i] = '0;
      hi0 = 0; lo0 = 0; hi1 = 0; lo1 = 0; sa_reg = 0;
      wb_queue.delete();
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[70:0];
        if (wb_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word %h", got);
        end else begin
          want = wb_queue.pop_front();
          if (got.wr_en !== want.wr_en || got.wr_index !== want.wr_index ||
              got.wr_value !== want.wr_value || got.div_err !== want.div_err) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp en=%b idx=%0d val=%h err=%b, %s",
                       want.wr_en, want.wr_index, want.wr_value, want.div_err,
                       $sformatf("got en=%b idx=%0d val=%h err=%b",
                                 got.wr_en, got.wr_index, got.wr_value, got.div_err));
          end
        end
      end
      if (in_tvalid && in_tready) execute_instr(in_tdata);
    end
    pending_count = wb_queue.size();
  end
endmodule

// ===== test/mips64_integer_execute_unit_tb.sv =====
// ----------------------------------------------------------------------------
// mips64_integer_execute_unit_tb
// Drives directed and random instruction words into the execute unit under
// varying idle and stall patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module mips64_integer_execute_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 20000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [71:0] out_tdata;
  int          fail_count, pending_count;
  int          send_idle_pct = 0, recv_stall_pct = 0;
  int          hold_off = 0;
  logic        hold_req = 0;
  logic        hold_done = 0;
  int          quiet_cycles = 0;

  mips64_integer_execute_unit DUT (.*);

  mips64_integer_execute_unit_checker u_checker (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // receiver: random stall, or a long forced hold-off
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1;
      hold_off <= 200;
      out_tready <= 0;
    end else if (hold_off > 0) begin
      out_tready <= 0;
      hold_off <= hold_off - 1;
    end else begin
      out_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [47:0] pack_instr(mips_ieu_pkg::cmd_t op, logic [4:0] rs,
                                             logic [4:0] rt, logic [4:0] rd,
                                             logic [4:0] sa, logic [15:0] imm);
    return {6'd0, imm, sa, rd, rt, rs, 6'(op)};
  endfunction

  task automatic send_word(input logic [47:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_op(mips_ieu_pkg::cmd_t op, int rs, int rt, int rd, int sa, int imm);
    send_word(pack_instr(op, 5'(rs), 5'(rt), 5'(rd), 5'(sa), 16'(imm)));
  endtask

  function automatic logic [15:0] rand_imm();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // a share of register writes via lui, ori/xori and dsll32 so operands become wide and varied
  task automatic send_random();
    int k;
    logic [47:0] w;
    k = $urandom_range(99);
    if (k < 15) begin
      send_op(mips_ieu_pkg::CMD_LUI, 0, $urandom_range(31), 0, 0, int'(rand_imm()));
    end else if (k < 25) begin
      send_op(mips_ieu_pkg::cmd_t'($urandom_range(32, 33)), $urandom_range(31),
              $urandom_range(31), 0, 0, int'(rand_imm()));
    end else if (k < 32) begin
      send_op(mips_ieu_pkg::CMD_DSLL32, 0, $urandom_range(31), $urandom_range(31),
              $urandom_range(31), 0);
    end else if (k < 36) begin
      send_op(mips_ieu_pkg::CMD_DIV, $urandom_range(31), $urandom_range(3), 0, 0, 0);
    end else if (k < 38) begin
      w = 48'({$urandom, $urandom});
      w[5:0] = 6'($urandom_range(50, 63));
      send_word(w);
    end else begin
      w = 48'({$urandom, $urandom});
      w[5:0] = 6'($urandom_range(49));
      w[47:42] = '0;
      send_word(w);
    end
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    int i;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: operand extremes, every op, divide corner cases
    send_op(mips_ieu_pkg::CMD_LUI, 0, 1, 0, 0, 16'h8000);    // r1 = 0xffffffff80000000
    send_op(mips_ieu_pkg::CMD_ADDIU, 0, 2, 0, 0, 16'hFFFF);  // r2 = -1
    send_op(mips_ieu_pkg::CMD_DIV, 1, 2, 0, 0, 0);           // signed overflow
    send_op(mips_ieu_pkg::CMD_MFLO, 0, 0, 3, 0, 0);
    send_op(mips_ieu_pkg::CMD_MFHI, 0, 0, 4, 0, 0);
    send_op(mips_ieu_pkg::CMD_DIV, 1, 0, 0, 0, 0);           // signed divide by zero
    send_op(mips_ieu_pkg::CMD_DIVU, 2, 0, 0, 0, 0);          // unsigned divide by zero
    send_op(mips_ieu_pkg::CMD_MFHI, 0, 0, 5, 0, 0);
    send_op(mips_ieu_pkg::CMD_DIVU1, 2, 1, 0, 0, 0);
    send_op(mips_ieu_pkg::CMD_MFLO1, 0, 0, 6, 0, 0);
    send_op(mips_ieu_pkg::CMD_MULT1, 2, 1, 7, 0, 0);
    send_op(mips_ieu_pkg::CMD_MFHI1, 0, 0, 8, 0, 0);
    send_op(mips_ieu_pkg::CMD_MOVZ, 2, 0, 9, 0, 0);
    send_op(mips_ieu_pkg::CMD_MOVN, 2, 0, 10, 0, 0);         // condition not met
    send_op(mips_ieu_pkg::CMD_ADDU, 2, 2, 0, 0, 0);          // write to register zero dropped
    send_op(mips_ieu_pkg::CMD_DSRA32, 0, 2, 11, 31, 0);
    send_op(mips_ieu_pkg::CMD_MTSA, 2, 0, 0, 0, 0);
    send_op(mips_ieu_pkg::CMD_MFSA, 0, 0, 12, 0, 0);
    send_word(48'h0000_0000_FFFF);                           // unused code, source and target index fields high
    for (i = 0; i < 50; i++)
      send_word(48'({$urandom, $urandom}) & 48'h03FF_FFFF_FFC0 | 48'(i));
    drain();
    // random phases with varied idle and stall rates, each ending with the sender idle until all results are back
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      if (phase == 2) hold_req <= 1;
      for (i = 0; i < 420; i++) send_random();
      drain();
    end
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
